// ----- sv/hbs_pkg.sv -----
// Shared types and constants for the hierarchical bitmap scan core.
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

    // Geometry of the bitmap.
    localparam int NUM_BITS   = 4096;
    localparam int WORD_BITS  = 64;
    localparam int IDX_W      = $clog2(WORD_BITS);
    localparam int POS_W      = $clog2(NUM_BITS);
    localparam int LEAF_WORDS = NUM_BITS / WORD_BITS;
    localparam int LEAF_AW    = $clog2(LEAF_WORDS);

    // Command codes carried by a transaction.
    typedef enum logic [1:0] {
        CMD_SET       = 2'd0,
        CMD_CLEAR     = 2'd1,
        CMD_SCAN_UP   = 2'd2,
        CMD_SCAN_DOWN = 2'd3
    } cmd_t;

    // Result of the shared bit finder.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] index;
    } find_res_t;

endpackage

`default_nettype wire

// ----- sv/hierarchical_bitmap_scan_core.sv -----
// Top level of the hierarchical bitmap scan core: sequencer, summary and result register.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_command[1:0], s_position[11:0]
//   m_        out        m_valid / m_ready  m_found, m_result_position[11:0]
//
// Set, clear and a scan that hits in its start word step through ST_LEAF and ST_DONE;
// a scan that misses there adds ST_SUM, and one that reads a second leaf word adds
// ST_SUM and ST_LEAF2; all steps share a single bit finder. One transaction is in
// flight, and s_ready returns the cycle after the result loads.
// The summary word resets to zero and masks the leaf RAM, so no clearing pass is needed.
// One result waiting on m_ready does not block the next input transaction; that one then
// holds in its final state until the output register drains.
`timescale 1ns / 1ps
`default_nettype none

module hierarchical_bitmap_scan_core
    import hbs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_command,
    input  wire logic [POS_W-1:0] s_position,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_found,
    output logic      [POS_W-1:0] m_result_position
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LEAF  = 5'b00010,
        ST_SUM   = 5'b00100,
        ST_LEAF2 = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_BITS-1:0] mid_reg, mid_next;
    logic [LEAF_AW-1:0]   leaf_idx_reg, leaf_idx_next;
    logic                 hit_reg, hit_next;
    logic [POS_W-1:0]     res_pos_reg, res_pos_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    logic [POS_W-1:0]     m_pos_reg, m_pos_next;

    logic [LEAF_AW-1:0]   word_idx;
    logic [IDX_W-1:0]     bit_idx;
    logic                 ram_we;
    logic [LEAF_AW-1:0]   ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic                 word_live;
    logic [WORD_BITS-1:0] leaf_word;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] leaf_from;
    logic [WORD_BITS-1:0] leaf_upto;
    logic [WORD_BITS-1:0] mid_from;
    logic [WORD_BITS-1:0] mid_upto;
    logic [WORD_BITS-1:0] find_word;
    logic                 downward;
    logic                 out_load;
    find_res_t            find_res;

    assign word_idx = pos_reg[POS_W-1:IDX_W];
    assign bit_idx  = pos_reg[IDX_W-1:0];
    assign downward = (cmd_reg == CMD_SCAN_DOWN);
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // A leaf word whose summary bit is clear is empty, whatever the RAM holds.
    assign word_live = (state_reg == ST_LEAF2) ? mid_reg[leaf_idx_reg] : mid_reg[word_idx];
    assign leaf_word = ram_rdata & {WORD_BITS{word_live}};

    // Range masks for the start word and the summary word.
    assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_idx;
    assign leaf_from = ONES << bit_idx;
    assign leaf_upto = ~(ONES << ({1'b0, bit_idx} + (IDX_W+1)'(1)));
    assign mid_from  = mid_reg & (ONES << ({1'b0, word_idx} + (LEAF_AW+1)'(1)));
    assign mid_upto  = mid_reg & ~(ONES << word_idx);

    // Operand select for the shared bit finder.
    always_comb begin
        case (state_reg)
            ST_LEAF:  find_word = leaf_word & (downward ? leaf_upto : leaf_from);
            ST_SUM:   find_word = downward ? mid_upto : mid_from;
            ST_LEAF2: find_word = leaf_word;
            default:  find_word = '0;
        endcase
    end

    hbs_find u_find (
        .word     (find_word),
        .downward (downward),
        .res      (find_res)
    );

    // Leaf RAM port: start word on acceptance, summary pick during the summary step.
    always_comb begin
        case (state_reg)
            ST_IDLE: ram_addr = s_position[POS_W-1:IDX_W];
            ST_SUM:  ram_addr = find_res.index;
            default: ram_addr = word_idx;
        endcase
        ram_we    = (state_reg == ST_LEAF) && (cmd_reg inside {CMD_SET, CMD_CLEAR});
        ram_wdata = (cmd_reg == CMD_SET) ? (leaf_word | bit_mask) : (leaf_word & ~bit_mask);
    end

    hbs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (LEAF_WORDS)
    ) u_leaf_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        mid_next      = mid_reg;
        leaf_idx_next = leaf_idx_reg;
        hit_next      = hit_reg;
        res_pos_next  = res_pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = cmd_t'(s_command);
                    pos_next   = s_position;
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF: begin
                hit_next     = 1'b0;
                res_pos_next = '0;
                case (cmd_reg)
                    CMD_SET: begin
                        mid_next[word_idx] = 1'b1;
                        state_next         = ST_DONE;
                    end
                    CMD_CLEAR: begin
                        if ((leaf_word & ~bit_mask) == '0) begin
                            mid_next[word_idx] = 1'b0;
                        end
                        state_next = ST_DONE;
                    end
                    default: begin
                        if (find_res.hit) begin
                            hit_next     = 1'b1;
                            res_pos_next = {word_idx, find_res.index};
                            state_next   = ST_DONE;
                        end else begin
                            state_next = ST_SUM;
                        end
                    end
                endcase
            end
            ST_SUM: begin
                if (find_res.hit) begin
                    leaf_idx_next = find_res.index;
                    state_next    = ST_LEAF2;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LEAF2: begin
                hit_next     = find_res.hit;
                res_pos_next = find_res.hit ? {leaf_idx_reg, find_res.index} : '0;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_pos_next   = m_pos_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_found_next = hit_reg;
            m_pos_next   = hit_reg ? res_pos_reg : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mid_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mid_reg     <= mid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        leaf_idx_reg <= leaf_idx_next;
        hit_reg      <= hit_next;
        res_pos_reg  <= res_pos_next;
        m_found_reg  <= m_found_next;
        m_pos_reg    <= m_pos_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = m_found_reg;
    assign m_result_position = m_pos_reg;

    // The block is busy in the cycle after it takes a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a transaction");

    // A set leaves the summary bit of its word marked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEAF && cmd_reg == CMD_SET) |=> mid_reg[word_idx])
        else $error("summary bit not set after set command");

    // A leaf word picked through the summary is never empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEAF2) |-> find_res.hit)
        else $error("summary marks an empty leaf word");

    // A result without a hit carries position zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_result_position == '0))
        else $error("nonzero position on a miss");

endmodule

`default_nettype wire

// ----- sv/hbs_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read in the cycle of a write returns the old word.
    // Read data lands in the cycle after the address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- sv/hbs_find.sv -----
// Shared bit finder: lowest or highest set bit of one 64-bit word.
`timescale 1ns / 1ps
`default_nettype none

module hbs_find
    import hbs_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic                 downward,
    output find_res_t                 res
);

    // Priority encoder; the direction picks which end wins.
    always_comb begin
        res.hit   = |word;
        res.index = '0;
        if (downward) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (word[i]) begin
                    res.index = IDX_W'(i);
                end
            end
        end else begin
            for (int i = WORD_BITS - 1; i >= 0; i--) begin
                if (word[i]) begin
                    res.index = IDX_W'(i);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_hierarchical_bitmap_scan_core.sv -----
// Self-checking testbench for the hierarchical bitmap scan core.
`timescale 1ns / 1ps

module tb_hierarchical_bitmap_scan_core;
    import hbs_pkg::*;

    // One result transaction as seen on the m_ channel.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } scan_reply_t;

    // One row of the directed table; pinned rows carry a hand-written reply.
    typedef struct {
        cmd_t             cmd;
        logic [POS_W-1:0] pos;
        bit               pinned;
        logic             found;
        logic [POS_W-1:0] reply_pos;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int ROUNDS        = 6;
    localparam int ROUND_ITEMS   = 242;
    localparam int RECENT_DEPTH  = 256;
    localparam int SETTLE_CYCLES = 16;

    // Per round: share of sets, share of clears and width of the address window.
    localparam int SET_PCT [ROUNDS] = '{40, 25, 15, 10, 30, 5};
    localparam int CLR_PCT [ROUNDS] = '{10, 20, 30, 40, 15, 45};
    localparam int SPAN    [ROUNDS] = '{4096, 256, 64, 4096, 512, 4096};

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_command = CMD_SET;
    logic [POS_W-1:0] s_position = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_found;
    logic [POS_W-1:0] m_result_position;

    // Shadow copy of the occupancy bitmap and its two summary levels.
    logic [WORD_BITS-1:0] occ_leaf [LEAF_WORDS] = '{default: '0};
    logic [WORD_BITS-1:0] occ_mid = '0;
    logic [WORD_BITS-1:0] occ_top = '0;

    scan_reply_t      replies_due [$];
    logic [POS_W-1:0] recent_sets [$];
    int               mismatch_count = 0;
    int               sender_quiet = 0;
    int               receiver_quiet = 0;

    // Directed rows: empty map, both ends, word and summary boundaries.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_SCAN_UP,   12'd0,    1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_DOWN, 12'd4095, 1'b1, 1'b0, 12'd0},
        '{CMD_SET,       12'd0,    1'b1, 1'b0, 12'd0},
        '{CMD_SET,       12'd4095, 1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_UP,   12'd0,    1'b1, 1'b1, 12'd0},
        '{CMD_SCAN_UP,   12'd1,    1'b1, 1'b1, 12'd4095},
        '{CMD_SCAN_DOWN, 12'd4094, 1'b1, 1'b1, 12'd0},
        '{CMD_SCAN_DOWN, 12'd4095, 1'b1, 1'b1, 12'd4095},
        '{CMD_SET,       12'd63,   1'b1, 1'b0, 12'd0},
        '{CMD_SET,       12'd64,   1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_UP,   12'd1,    1'b1, 1'b1, 12'd63},
        '{CMD_CLEAR,     12'd63,   1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_UP,   12'd1,    1'b1, 1'b1, 12'd64},
        '{CMD_CLEAR,     12'd63,   1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_DOWN, 12'd127,  1'b1, 1'b1, 12'd64},
        '{CMD_CLEAR,     12'd64,   1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_UP,   12'd1,    1'b1, 1'b1, 12'd4095},
        '{CMD_CLEAR,     12'd0,    1'b1, 1'b0, 12'd0},
        '{CMD_CLEAR,     12'd4095, 1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_UP,   12'd0,    1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_DOWN, 12'd4095, 1'b1, 1'b0, 12'd0},
        '{CMD_SET,       12'hAAA,  1'b1, 1'b0, 12'd0},
        '{CMD_SET,       12'h555,  1'b1, 1'b0, 12'd0},
        '{CMD_SCAN_UP,   12'h556,  1'b0, 1'b0, 12'd0},
        '{CMD_SCAN_DOWN, 12'hAA9,  1'b0, 1'b0, 12'd0}
    };

    hierarchical_bitmap_scan_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_position        (s_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_result_position (m_result_position)
    );

    always #2 aclk = ~aclk;

    function automatic logic [IDX_W-1:0] lowest_set(logic [WORD_BITS-1:0] w);
        for (int n = 0; n < WORD_BITS; n++) begin
            if (w[n]) return IDX_W'(n);
        end
        return IDX_W'(WORD_BITS - 1);
    endfunction

    function automatic logic [IDX_W-1:0] highest_set(logic [WORD_BITS-1:0] w);
        for (int n = WORD_BITS - 1; n >= 0; n--) begin
            if (w[n]) return IDX_W'(n);
        end
        return '0;
    endfunction

    // Nearest set position at or above start. Only one middle word exists, so the
    // top summary never points past it and a miss there ends the scan.
    function automatic scan_reply_t search_upward(logic [POS_W-1:0] start);
        logic [LEAF_AW-1:0]   w0;
        logic [WORD_BITS-1:0] w;
        logic [WORD_BITS-1:0] s;
        logic [LEAF_AW-1:0]   n0;
        w0 = start[POS_W-1:IDX_W];
        w  = occ_leaf[w0] & ({WORD_BITS{1'b1}} << start[IDX_W-1:0]);
        if (w != '0) return '{1'b1, {w0, lowest_set(w)}};
        s = occ_mid & ({WORD_BITS{1'b1}} << (int'(w0) + 1));
        if (s == '0) return '0;
        n0 = lowest_set(s);
        if (occ_leaf[n0] == '0) return '0;
        return '{1'b1, {n0, lowest_set(occ_leaf[n0])}};
    endfunction

    // Nearest set position at or below start.
    function automatic scan_reply_t search_downward(logic [POS_W-1:0] start);
        logic [LEAF_AW-1:0]   w0;
        logic [WORD_BITS-1:0] w;
        logic [WORD_BITS-1:0] s;
        logic [LEAF_AW-1:0]   n0;
        w0 = start[POS_W-1:IDX_W];
        w  = occ_leaf[w0] & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - int'(start[IDX_W-1:0])));
        if (w != '0) return '{1'b1, {w0, highest_set(w)}};
        if (w0 == '0) return '0;
        s = occ_mid & ({WORD_BITS{1'b1}} >> (WORD_BITS - int'(w0)));
        if (s == '0) return '0;
        n0 = highest_set(s);
        if (occ_leaf[n0] == '0) return '0;
        return '{1'b1, {n0, highest_set(occ_leaf[n0])}};
    endfunction

    // Applies one command to the shadow bitmap and returns the reply it should give.
    function automatic scan_reply_t bitmap_apply(cmd_t cmd, logic [POS_W-1:0] pos);
        logic [LEAF_AW-1:0] w0;
        w0 = pos[POS_W-1:IDX_W];
        case (cmd)
            CMD_SET: begin
                occ_leaf[w0][pos[IDX_W-1:0]] = 1'b1;
                occ_mid[w0] = 1'b1;
                occ_top[0]  = 1'b1;
                return '0;
            end
            CMD_CLEAR: begin
                occ_leaf[w0][pos[IDX_W-1:0]] = 1'b0;
                if (occ_leaf[w0] == '0) begin
                    occ_mid[w0] = 1'b0;
                    if (occ_mid == '0) occ_top[0] = 1'b0;
                end
                return '0;
            end
            CMD_SCAN_UP:   return search_upward(pos);
            default:       return search_downward(pos);
        endcase
    endfunction

    // Cycles to hold off before the next transaction, with occasional busy stretches.
    function automatic int draw_idle(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left = $urandom_range(15, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Random position: boundaries, neighbors of recent sets, or the current window.
    function automatic logic [POS_W-1:0] pick_position(int base, int span);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, LEAF_WORDS - 1);
        if (r < 15) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return POS_W'(NUM_BITS - 1);
                2:       return POS_W'(k * WORD_BITS);
                default: return POS_W'(k * WORD_BITS + WORD_BITS - 1);
            endcase
        end
        if (r < 50 && recent_sets.size() > 0)
            return POS_W'(int'(recent_sets[$urandom_range(0, recent_sets.size() - 1)])
                          + int'($urandom_range(0, 6)) - 3);
        return POS_W'(base + int'($urandom_range(0, span - 1)));
    endfunction

    // Drives one input transaction and records its reply once it is accepted.
    task automatic send_command(cmd_t cmd, logic [POS_W-1:0] pos, bit pinned,
                                scan_reply_t pinned_reply);
        int          gap;
        scan_reply_t predicted;
        gap = draw_idle(sender_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        predicted = bitmap_apply(cmd, pos);
        replies_due.insert(replies_due.size(), pinned ? pinned_reply : predicted);
    endtask

    // Result side: random stalls on m_ready, each transaction checked in order.
    initial begin
        int          gap;
        scan_reply_t want;
        wait (aresetn === 1'b1);
        forever begin
            gap = draw_idle(receiver_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (replies_due.size() == 0) begin
                $error("unexpected result: found %0d position %0d", m_found, m_result_position);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                if (m_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_found);
                    mismatch_count++;
                end
                if (m_result_position !== want.position) begin
                    $error("result_position: expected %0d, actual %0d",
                           want.position, m_result_position);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then rounds of random traffic.
    initial begin
        int               r;
        int               base;
        int               idx;
        cmd_t             cmd;
        logic [POS_W-1:0] pos;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].pinned,
                         '{directed_rows[i].found, directed_rows[i].reply_pos});
        end

        // Rounds shift from filling the map to thinning it; the fifth fills again.
        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            base = $urandom_range(0, NUM_BITS - 1);
            for (int i = 0; i < ROUND_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < SET_PCT[rnd]) begin
                    cmd = CMD_SET;
                    pos = pick_position(base, SPAN[rnd]);
                    recent_sets.insert(recent_sets.size(), pos);
                    if (recent_sets.size() > RECENT_DEPTH) void'(recent_sets.pop_front());
                end else if (r < SET_PCT[rnd] + CLR_PCT[rnd]) begin
                    cmd = CMD_CLEAR;
                    if (recent_sets.size() > 0 && $urandom_range(0, 9) < 6) begin
                        idx = $urandom_range(0, recent_sets.size() - 1);
                        pos = recent_sets[idx];
                        recent_sets.delete(idx);
                    end else begin
                        pos = pick_position(base, SPAN[rnd]);
                    end
                end else begin
                    cmd = $urandom_range(0, 1) ? CMD_SCAN_UP : CMD_SCAN_DOWN;
                    pos = pick_position(base, SPAN[rnd]);
                end
                send_command(cmd, pos, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (replies_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hbs_pkg.sv
sv/hbs_ram.sv
sv/hbs_find.sv
sv/hierarchical_bitmap_scan_core.sv
verif/tb_hierarchical_bitmap_scan_core.sv
